@@ rtl/ipv4_fragment_header_generator_defines.svh @@
// ----------------------------------------------------------------------------
// IPv4 fragment header generator assertion macros
// Shared concurrent assertion forms, clocked on clock and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef IPV4_FRAGMENT_HEADER_GENERATOR_DEFINES_SVH
`define IPV4_FRAGMENT_HEADER_GENERATOR_DEFINES_SVH

// same-cycle implication
`define IFHG_ASSERT_NOW(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ifhg assertion failed");

// next-cycle implication
`define IFHG_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ifhg assertion failed");

`endif

@@ rtl/ifhg_pkg.sv @@
// ----------------------------------------------------------------------------
// IPv4 fragment header generator package
// Constants and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package ifhg_pkg;

   // default largest fragment payload in bytes
   localparam int MAX_FRAG_PAYLOAD = 1480;
   // most headers emitted for one datagram
   localparam int RESULT_CAP       = 45;
   localparam int CNT_W            = $clog2(RESULT_CAP + 1);

   localparam int HDR_LEN      = 20;
   localparam int TOTAL_LEN_W  = 11;
   localparam int OFFSET_W     = 13;
   localparam logic [15:0] VER_IHL_TOS = 16'h4500;
   localparam logic [7:0]  TTL         = 8'd64;

   // controller to datapath
   typedef struct packed {
      logic load;    // latch descriptor
      logic base;    // compute per-datagram checksum base
      logic calc;    // compute next fragment header
      logic finish;  // last word taken, bump identification
   } ctl_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic last;    // header held in the output register is the final one
   } ctl_status_type;

endpackage

@@ rtl/ifhg_req_if.sv @@
// ----------------------------------------------------------------------------
// Request channel interface
// Datagram descriptor word with valid/ready handshake.
// ----------------------------------------------------------------------------
interface ifhg_req_if;
   logic        valid;
   logic        ready;
   logic [15:0] payload_len;
   logic [31:0] dest_ip;
   logic [7:0]  protocol;

   modport source (output valid, payload_len, dest_ip, protocol, input ready);
   modport sink   (input valid, payload_len, dest_ip, protocol, output ready);
endinterface

@@ rtl/ifhg_rsp_if.sv @@
// ----------------------------------------------------------------------------
// Response channel interface
// One IPv4 fragment header word per handshake.
// ----------------------------------------------------------------------------
interface ifhg_rsp_if;
   logic        valid;
   logic        ready;
   logic [10:0] total_len;
   logic [15:0] ident;
   logic [12:0] frag_offset;
   logic        more_fragments;
   logic [15:0] header_checksum;
   logic [7:0]  proto_out;
   logic [31:0] dest_out;
   logic        last;

   modport source (output valid, total_len, ident, frag_offset, more_fragments,
                   header_checksum, proto_out, dest_out, last, input ready);
   modport sink   (input valid, total_len, ident, frag_offset, more_fragments,
                   header_checksum, proto_out, dest_out, last, output ready);
endinterface

@@ rtl/ifhg_datapath.sv @@
// ----------------------------------------------------------------------------
// IPv4 fragment header datapath
// Split tracking, identification counter, source register and checksum.
// ----------------------------------------------------------------------------
module ifhg_datapath #(
   parameter int MAX_FRAG_PAYLOAD = ifhg_pkg::MAX_FRAG_PAYLOAD
) (
   input  logic                   clock,
   input  logic                   reset,
   input  ifhg_pkg::ctl_cmd_type  cmd,
   output ifhg_pkg::ctl_status_type status,
   input  logic                   csr_write,
   input  logic [31:0]            csr_wdata,
   input  logic [15:0]            payload_len,
   input  logic [31:0]            dest_ip,
   input  logic [7:0]             protocol,
   output logic [10:0]            total_len,
   output logic [15:0]            ident,
   output logic [12:0]            frag_offset,
   output logic                   more_fragments,
   output logic [15:0]            header_checksum,
   output logic [7:0]             proto_out,
   output logic [31:0]            dest_out,
   output logic                   last
);

   // fragment size rounded down to a multiple of 8, at least 8
   localparam int FRAG_MASKED = MAX_FRAG_PAYLOAD & 'hFFF8;
   localparam int FRAG_BYTES  = (FRAG_MASKED == 0) ? 8 : FRAG_MASKED;
   localparam logic [15:0] FRAG_LEN   = 16'(FRAG_BYTES);
   localparam logic [12:0] FRAG_UNITS = 13'(FRAG_BYTES >> 3);
   localparam int CNT_W = ifhg_pkg::CNT_W;

   logic [31:0] local_ip_ff, local_ip_in;
   logic [15:0] ident_ff, ident_in;
   logic [31:0] dst_ff, dst_in;
   logic [7:0]  proto_ff, proto_in;
   logic [19:0] base_ff, base_in;
   logic [15:0] remaining_ff, remaining_in;
   logic [12:0] offset_ff, offset_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [10:0] tlen_out_ff, tlen_out_in;
   logic [12:0] off_out_ff, off_out_in;
   logic        mf_ff, mf_in;
   logic [15:0] cksum_ff, cksum_in;
   logic        last_ff, last_in;

   logic             mf;
   logic [15:0]      chunk;
   logic [15:0]      tlen;
   logic [15:0]      flagoff;
   logic [CNT_W-1:0] count_next;
   logic [19:0]      sum;
   logic [16:0]      fold1;
   logic [16:0]      fold2;

   // per-fragment split and checksum fold
   always_comb begin
      mf         = remaining_ff > FRAG_LEN;
      chunk      = mf ? FRAG_LEN : remaining_ff;
      tlen       = chunk + 16'(ifhg_pkg::HDR_LEN);
      flagoff    = {2'b00, mf, offset_ff};
      count_next = count_ff + CNT_W'(1);
      sum        = base_ff + {4'b0000, tlen} + {4'b0000, flagoff};
      // two end-around folds cover a 20-bit sum
      fold1      = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
      fold2      = {1'b0, fold1[15:0]} + {16'd0, fold1[16]};
   end

   // next-state values
   always_comb begin
      local_ip_in  = csr_write ? csr_wdata : local_ip_ff;
      ident_in     = cmd.finish ? ident_ff + 16'd1 : ident_ff;
      dst_in       = cmd.load ? dest_ip : dst_ff;
      proto_in     = cmd.load ? protocol : proto_ff;
      // constant header words plus addresses and identification
      base_in      = cmd.base ?
                     {4'b0000, ifhg_pkg::VER_IHL_TOS} + {4'b0000, ifhg_pkg::TTL, proto_ff}
                     + {4'b0000, local_ip_ff[31:16]} + {4'b0000, local_ip_ff[15:0]}
                     + {4'b0000, dst_ff[31:16]} + {4'b0000, dst_ff[15:0]}
                     + {4'b0000, ident_ff}
                     : base_ff;
      remaining_in = remaining_ff;
      offset_in    = offset_ff;
      count_in     = count_ff;
      tlen_out_in  = tlen_out_ff;
      off_out_in   = off_out_ff;
      mf_in        = mf_ff;
      cksum_in     = cksum_ff;
      last_in      = last_ff;
      if (cmd.load) begin
         remaining_in = payload_len;
         offset_in    = '0;
         count_in     = '0;
      end else if (cmd.calc) begin
         remaining_in = remaining_ff - chunk;
         offset_in    = offset_ff + FRAG_UNITS;
         count_in     = count_next;
         tlen_out_in  = tlen[10:0];
         off_out_in   = offset_ff;
         mf_in        = mf;
         cksum_in     = ~fold2[15:0];
         last_in      = !mf || (count_next >= CNT_W'(ifhg_pkg::RESULT_CAP));
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         local_ip_ff <= '0;
         ident_ff    <= '0;
      end else begin
         local_ip_ff <= local_ip_in;
         ident_ff    <= ident_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      dst_ff       <= dst_in;
      proto_ff     <= proto_in;
      base_ff      <= base_in;
      remaining_ff <= remaining_in;
      offset_ff    <= offset_in;
      count_ff     <= count_in;
      tlen_out_ff  <= tlen_out_in;
      off_out_ff   <= off_out_in;
      mf_ff        <= mf_in;
      cksum_ff     <= cksum_in;
      last_ff      <= last_in;
   end

   assign status.last     = last_ff;
   assign total_len       = tlen_out_ff;
   assign ident           = ident_ff;
   assign frag_offset     = off_out_ff;
   assign more_fragments  = mf_ff;
   assign header_checksum = cksum_ff;
   assign proto_out       = proto_ff;
   assign dest_out        = dst_ff;
   assign last            = last_ff;

endmodule

@@ rtl/ifhg_controller.sv @@
// ----------------------------------------------------------------------------
// IPv4 fragment header controller
// Sequences descriptor load, checksum base, and per-fragment emit.
// ----------------------------------------------------------------------------
`include "ipv4_fragment_header_generator_defines.svh"

module ifhg_controller (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   output logic                     req_ready,
   output logic                     rsp_valid,
   input  logic                     rsp_ready,
   output ifhg_pkg::ctl_cmd_type    cmd,
   input  ifhg_pkg::ctl_status_type status
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_BASE = 4'b0010,
      ST_CALC = 4'b0100,
      ST_EMIT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   // handshake and commands
   always_comb begin
      req_ready  = state_ff == ST_IDLE;
      rsp_valid  = state_ff == ST_EMIT;
      cmd.load   = req_valid && req_ready;
      cmd.base   = state_ff == ST_BASE;
      cmd.calc   = state_ff == ST_CALC;
      cmd.finish = rsp_valid && rsp_ready && status.last;
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) state_in = ST_BASE;
         end
         ST_BASE: begin
            state_in = ST_CALC;
         end
         ST_CALC: begin
            state_in = ST_EMIT;
         end
         ST_EMIT: begin
            if (rsp_ready) state_in = status.last ? ST_IDLE : ST_CALC;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // never take a descriptor while a header word is pending
   `IFHG_ASSERT_NOW(a_ready_excl, req_ready, !rsp_valid)
   // final word taken returns to accepting descriptors
   `IFHG_ASSERT_NEXT(a_last_idle, rsp_valid && rsp_ready && status.last, req_ready)
   // non-final word taken goes on to compute the next header
   `IFHG_ASSERT_NEXT(a_more_calc, rsp_valid && rsp_ready && !status.last,
                     cmd.calc && !req_ready)

endmodule

@@ rtl/ipv4_fragment_header_generator.sv @@
// First header word valid once the descriptor is accepted and the base and compute states have run.
// Header words come from the alternating compute and emit states; each word is held in the
//   emit state until it is taken, so output stalls hold the flow.
// Descriptor ready again the cycle after the final header word is taken.
// Reset (synchronous, active high) clears the controller, the identification
//   counter and local_ip; no clearing pass.
// ----------------------------------------------------------------------------
// IPv4 fragment header generator
// Splits a datagram descriptor into IPv4 fragment header words.
// ----------------------------------------------------------------------------
module ipv4_fragment_header_generator #(
   parameter int MAX_FRAG_PAYLOAD = ifhg_pkg::MAX_FRAG_PAYLOAD
) (
   input  logic         clock,
   input  logic         reset,
   ifhg_req_if.sink     req_bus,
   ifhg_rsp_if.source   rsp_bus,
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [31:0]  csr_wdata
);

   ifhg_pkg::ctl_cmd_type    cmd;
   ifhg_pkg::ctl_status_type status;

   // source address register always takes a write
   assign csr_ready = 1'b1;

   ifhg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .cmd       (cmd),
      .status    (status)
   );

   ifhg_datapath #(
      .MAX_FRAG_PAYLOAD (MAX_FRAG_PAYLOAD)
   ) u_dp (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .status          (status),
      .csr_write       (csr_valid && csr_ready),
      .csr_wdata       (csr_wdata),
      .payload_len     (req_bus.payload_len),
      .dest_ip         (req_bus.dest_ip),
      .protocol        (req_bus.protocol),
      .total_len       (rsp_bus.total_len),
      .ident           (rsp_bus.ident),
      .frag_offset     (rsp_bus.frag_offset),
      .more_fragments  (rsp_bus.more_fragments),
      .header_checksum (rsp_bus.header_checksum),
      .proto_out       (rsp_bus.proto_out),
      .dest_out        (rsp_bus.dest_out),
      .last            (rsp_bus.last)
   );

endmodule
